/* rtl/box_filter_7x7_rgb_core_defines.svh */
// assertion macros shared by the box filter rtl
`ifndef BOX_FILTER_7X7_RGB_CORE_DEFINES_SVH
`define BOX_FILTER_7X7_RGB_CORE_DEFINES_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define BF7X7_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("box filter check failed");

// next-cycle implication
`define BF7X7_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("box filter check failed");

`endif

/* rtl/bf7x7_pkg.sv */
// shared types and constants of the 7x7 box filter
`default_nettype none

package bf7x7_pkg;

   localparam int KERNEL_SIZE  = 7;
   localparam int STORE_ROWS   = KERNEL_SIZE - 1;
   localparam int AREA         = KERNEL_SIZE * KERNEL_SIZE;
   localparam int NUM_CHAN     = 3;
   localparam int CHAN_W       = 8;
   localparam int CHAN_MAX     = (2 ** CHAN_W) - 1;
   localparam int PIX_W        = NUM_CHAN * CHAN_W;
   localparam int DIM_W        = 12;
   localparam int ROW_W        = 11;
   localparam int ANCHOR_W     = 11;
   localparam int SLOT_W       = $clog2(STORE_ROWS);
   localparam int COLSUM_W     = $clog2(KERNEL_SIZE * CHAN_MAX + 1);
   localparam int SUM_W        = $clog2(AREA * CHAN_MAX + 1);
   localparam int RECIP_SHIFT  = 20;
   localparam int RECIP        = ((2 ** RECIP_SHIFT) + AREA - 1) / AREA;
   localparam int RECIP_W      = $clog2(RECIP + 1);
   localparam int PROD_W       = SUM_W + RECIP_W;
   localparam int MAX_HEIGHT   = 2048;
   localparam int WIDTH_RESET  = 640;
   localparam int HEIGHT_RESET = 480;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   localparam int CH_BLUE  = 0;
   localparam int CH_GREEN = 1;
   localparam int CH_RED   = 2;

   typedef logic [CHAN_W-1:0]   chan_type;
   typedef logic [PIX_W-1:0]    pix_type;
   typedef logic [COLSUM_W-1:0] colsum_type;
   typedef logic [SUM_W-1:0]    sum_type;
   typedef logic [DIM_W-1:0]    dim_type;
   typedef logic [SLOT_W-1:0]   slot_type;

   typedef enum logic {
      REG_WIDTH  = 1'b0,
      REG_HEIGHT = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic                emit;
      logic                last;
      logic [ANCHOR_W-1:0] anchor_x;
      logic [ANCHOR_W-1:0] anchor_y;
   } meta_type;

endpackage

`default_nettype wire

/* rtl/bf7x7_req_if.sv */
// pixel input channel
`default_nettype none

interface bf7x7_req_if;
   import bf7x7_pkg::*;

   logic     valid;
   logic     ready;
   chan_type blue_in;
   chan_type green_in;
   chan_type red_in;

   modport source (output valid, output blue_in, output green_in, output red_in,
                   input ready);
   modport sink (input valid, input blue_in, input green_in, input red_in,
                 output ready);
endinterface

`default_nettype wire

/* rtl/bf7x7_rsp_if.sv */
// window mean result channel
`default_nettype none

interface bf7x7_rsp_if;
   import bf7x7_pkg::*;

   logic                valid;
   logic                ready;
   logic [ANCHOR_W-1:0] anchor_x;
   logic [ANCHOR_W-1:0] anchor_y;
   chan_type            blue_mean;
   chan_type            green_mean;
   chan_type            red_mean;
   logic                frame_last;

   modport source (output valid, output anchor_x, output anchor_y, output blue_mean,
                   output green_mean, output red_mean, output frame_last,
                   input ready);
   modport sink (input valid, input anchor_x, input anchor_y, input blue_mean,
                 input green_mean, input red_mean, input frame_last,
                 output ready);
endinterface

`default_nettype wire

/* rtl/bf7x7_csr.sv */
// frame size registers behind the apb-style port
`default_nettype none

module bf7x7_csr #(
   parameter int MAX_WIDTH = 2048
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [bf7x7_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [bf7x7_pkg::CSR_DATA_W-1:0] pwdata,
   output      logic [bf7x7_pkg::CSR_DATA_W-1:0] prdata,
   output      logic                           pready,
   output      bf7x7_pkg::dim_type             width,
   output      bf7x7_pkg::dim_type             height,
   output      logic                           cfg_write
);
   import bf7x7_pkg::*;

   localparam int CMP_W = DIM_W + 2;
   localparam logic [CMP_W-1:0] WIDTH_HI  = CMP_W'(MAX_WIDTH);
   localparam logic [CMP_W-1:0] HEIGHT_HI = CMP_W'(MAX_HEIGHT);

   dim_type       width_ff, width_in;
   dim_type       height_ff, height_in;
   reg_index_type index;
   logic          write_hit;

   function automatic dim_type clamp_dim(input dim_type v, input logic [CMP_W-1:0] hi);
      dim_type r;
      if (CMP_W'(v) < CMP_W'(KERNEL_SIZE)) begin
         r = DIM_W'(KERNEL_SIZE);
      end else if (CMP_W'(v) > hi) begin
         r = hi[DIM_W-1:0];
      end else begin
         r = v;
      end
      return r;
   endfunction

   assign pready    = 1'b1;
   assign index     = reg_index_type'(paddr[2]);
   assign write_hit = psel && penable && pwrite && pready;
   assign cfg_write = write_hit;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (write_hit) begin
         unique case (index)
            REG_WIDTH:  width_in  = clamp_dim(pwdata[DIM_W-1:0], WIDTH_HI);
            REG_HEIGHT: height_in = clamp_dim(pwdata[DIM_W-1:0], HEIGHT_HI);
            default:    width_in  = width_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_WIDTH:  prdata = CSR_DATA_W'(width_ff);
         REG_HEIGHT: prdata = CSR_DATA_W'(height_ff);
         default:    prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_W'(WIDTH_RESET);
         height_ff <= DIM_W'(HEIGHT_RESET);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   assign width  = width_ff;
   assign height = height_ff;
endmodule

`default_nettype wire

/* rtl/bf7x7_raster.sv */
// raster position counters, line store slot and window position flags
`default_nettype none

module bf7x7_raster #(
   parameter int MAX_WIDTH = 2048
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                accept,
   input  wire logic                                cfg_write,
   input  wire bf7x7_pkg::dim_type                  width,
   input  wire bf7x7_pkg::dim_type                  height,
   output      logic [$clog2(MAX_WIDTH)-1:0]        addr,
   output      bf7x7_pkg::slot_type                 slot,
   output      bf7x7_pkg::meta_type                 pos
);
   import bf7x7_pkg::*;

   localparam int AW    = $clog2(MAX_WIDTH);
   localparam int CNT_W = (AW > DIM_W) ? AW : DIM_W;

   logic [CNT_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   slot_type         slot_ff, slot_in;
   logic             col_last;
   logic             row_last;
   logic [CNT_W-1:0] col_off;
   logic [ROW_W-1:0] row_off;

   assign col_last = col_ff == (CNT_W'(width) - CNT_W'(1));
   assign row_last = DIM_W'(row_ff) == (height - DIM_W'(1));
   assign col_off  = col_ff - CNT_W'(KERNEL_SIZE - 1);
   assign row_off  = row_ff - ROW_W'(KERNEL_SIZE - 1);

   always_comb begin
      pos.emit     = (col_ff >= CNT_W'(KERNEL_SIZE - 1)) &&
                     (row_ff >= ROW_W'(KERNEL_SIZE - 1));
      pos.last     = col_last && row_last;
      pos.anchor_x = col_off[ANCHOR_W-1:0];
      pos.anchor_y = row_off[ANCHOR_W-1:0];
   end

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      slot_in = slot_ff;
      priority if (cfg_write) begin
         col_in  = '0;
         row_in  = '0;
         slot_in = '0;
      end else if (accept) begin
         if (col_last) begin
            col_in = '0;
            if (row_last) begin
               row_in  = '0;
               slot_in = '0;
            end else begin
               row_in  = row_ff + ROW_W'(1);
               // slot follows row modulo the number of stored lines
               slot_in = (slot_ff == SLOT_W'(STORE_ROWS - 1)) ? '0 : slot_ff + SLOT_W'(1);
            end
         end else begin
            col_in = col_ff + CNT_W'(1);
         end
      end else begin
         col_in  = col_ff;
         row_in  = row_ff;
         slot_in = slot_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         slot_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         slot_ff <= slot_in;
      end
   end

   assign addr = col_ff[AW-1:0];
   assign slot = slot_ff;
endmodule

`default_nettype wire

/* rtl/bf7x7_line_store.sv */
// six line memories, one write and one registered read per line each cycle
`default_nettype none

module bf7x7_line_store #(
   parameter int MAX_WIDTH = 2048
) (
   input  wire logic                                      clock,
   input  wire logic                                      read_en,
   input  wire logic                                      write_en,
   input  wire bf7x7_pkg::slot_type                       slot,
   input  wire logic [$clog2(MAX_WIDTH)-1:0]              addr,
   input  wire bf7x7_pkg::pix_type                        wdata,
   output      bf7x7_pkg::pix_type [bf7x7_pkg::STORE_ROWS-1:0] rdata
);
   import bf7x7_pkg::*;

   for (genvar g = 0; g < STORE_ROWS; g++) begin : g_line
      pix_type mem [MAX_WIDTH];
      pix_type rd_ff;

      // read before write: the slot being written still returns the old line
      always_ff @(posedge clock) begin
         if (read_en) begin
            rd_ff <= mem[addr];
         end
         if (write_en && (slot == SLOT_W'(g))) begin
            mem[addr] <= wdata;
         end
      end

      assign rdata[g] = rd_ff;
   end
endmodule

`default_nettype wire

/* rtl/bf7x7_window.sv */
// column sums, column sum shift line and window sum pipeline
`default_nettype none

module bf7x7_window (
   input  wire logic                                         clock,
   input  wire logic                                         reset,
   input  wire logic                                         in_valid,
   input  wire bf7x7_pkg::pix_type                           pixel,
   input  wire bf7x7_pkg::meta_type                          pos,
   input  wire bf7x7_pkg::pix_type [bf7x7_pkg::STORE_ROWS-1:0] lines,
   input  wire logic                                         out_free,
   output      logic                                         in_ready,
   output      logic                                         sum_valid,
   output      bf7x7_pkg::sum_type [bf7x7_pkg::NUM_CHAN-1:0] sum,
   output      bf7x7_pkg::meta_type                          sum_meta
);
   import bf7x7_pkg::*;

   logic va_ff, vb_ff, vc_ff;
   logic en_a, en_b, en_c;

   pix_type  pix_a_ff;
   meta_type meta_a_ff, meta_b_ff, meta_c_ff;

   colsum_type [NUM_CHAN-1:0] colsum_in;
   colsum_type [NUM_CHAN-1:0] colsum_b_ff;
   colsum_type [NUM_CHAN-1:0] cs_ff [STORE_ROWS];
   sum_type    [NUM_CHAN-1:0] sum_in;
   sum_type    [NUM_CHAN-1:0] sum_c_ff;

   assign en_c     = !vc_ff || out_free;
   assign en_b     = !vb_ff || en_c;
   assign en_a     = !va_ff || en_b;
   assign in_ready = en_a;

   // one column of the window: six stored lines plus the new pixel
   always_comb begin
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
         colsum_in[ch] = COLSUM_W'(pix_a_ff[ch*CHAN_W +: CHAN_W]);
         for (int r = 0; r < STORE_ROWS; r++) begin
            colsum_in[ch] = colsum_in[ch] + COLSUM_W'(lines[r][ch*CHAN_W +: CHAN_W]);
         end
      end
   end

   // newest column plus the six before it
   always_comb begin
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
         sum_in[ch] = SUM_W'(colsum_b_ff[ch]);
         for (int r = 0; r < STORE_ROWS; r++) begin
            sum_in[ch] = sum_in[ch] + SUM_W'(cs_ff[r][ch]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else begin
         if (en_a) begin
            va_ff <= in_valid;
         end
         if (en_b) begin
            vb_ff <= va_ff;
         end
         if (en_c) begin
            vc_ff <= vb_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en_a) begin
         pix_a_ff  <= pixel;
         meta_a_ff <= pos;
      end
      if (en_b) begin
         colsum_b_ff <= colsum_in;
         meta_b_ff   <= meta_a_ff;
      end
      if (en_c) begin
         sum_c_ff  <= sum_in;
         meta_c_ff <= meta_b_ff;
      end
      if (en_c && vb_ff) begin
         cs_ff[0] <= colsum_b_ff;
         for (int r = 1; r < STORE_ROWS; r++) begin
            cs_ff[r] <= cs_ff[r-1];
         end
      end
   end

   assign sum_valid = vc_ff;
   assign sum       = sum_c_ff;
   assign sum_meta  = meta_c_ff;
endmodule

`default_nettype wire

/* rtl/bf7x7_mean.sv */
// divide window sums by the window area and hold the result item
`default_nettype none

module bf7x7_mean (
   input  wire logic                                         clock,
   input  wire logic                                         reset,
   input  wire logic                                         in_valid,
   input  wire bf7x7_pkg::sum_type [bf7x7_pkg::NUM_CHAN-1:0] sum,
   input  wire bf7x7_pkg::meta_type                          meta,
   output      logic                                         free,
   bf7x7_rsp_if.source                                       rsp
);
   import bf7x7_pkg::*;

   localparam logic [PROD_W-1:0] RECIP_P = PROD_W'(RECIP);

   logic                 valid_ff;
   logic [PROD_W-1:0]    prod [NUM_CHAN];
   chan_type             quot_in [NUM_CHAN];
   chan_type             quot_ff [NUM_CHAN];
   meta_type             meta_ff;

   // floor(s / 49) as a multiply by a rounded-up reciprocal, exact for every sum
   always_comb begin
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
         prod[ch]    = PROD_W'(sum[ch]) * RECIP_P;
         quot_in[ch] = prod[ch][RECIP_SHIFT +: CHAN_W];
      end
   end

   assign free = !valid_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (free) begin
         valid_ff <= in_valid && meta.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (free) begin
         quot_ff <= quot_in;
         meta_ff <= meta;
      end
   end

   assign rsp.valid      = valid_ff;
   assign rsp.anchor_x   = meta_ff.anchor_x;
   assign rsp.anchor_y   = meta_ff.anchor_y;
   assign rsp.blue_mean  = quot_ff[CH_BLUE];
   assign rsp.green_mean = quot_ff[CH_GREEN];
   assign rsp.red_mean   = quot_ff[CH_RED];
   assign rsp.frame_last = meta_ff.last;
endmodule

`default_nettype wire

/* rtl/box_filter_7x7_rgb_core.sv */
// 7x7 box filter, rgb raster: one pixel in per cycle if not stalled, one mean per full window
// an accepted pixel passes the input, column sum, window sum and result registers to rsp_if
// throughput: 1 pixel per cycle, set by one read and one write per line memory each cycle
// result registers are spread over four stages that advance independently under back-pressure
// reset: synchronous, clears position counters, stage valids, frame size to 640x480
// line memories are not cleared; every window reads only lines written in the current frame
`default_nettype none

`include "box_filter_7x7_rgb_core_defines.svh"

module box_filter_7x7_rgb_core #(
   parameter int MAX_WIDTH = 2048
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   bf7x7_req_if.sink                             req_if,
   bf7x7_rsp_if.source                           rsp_if,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [bf7x7_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [bf7x7_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output      logic [bf7x7_pkg::CSR_DATA_W-1:0] csr_prdata,
   output      logic                             csr_pready
);
   import bf7x7_pkg::*;

   localparam int AW = $clog2(MAX_WIDTH);

   dim_type                    cfg_width;
   dim_type                    cfg_height;
   logic                       cfg_write;
   logic                       accept;
   logic                       in_ready;
   logic [AW-1:0]              addr;
   slot_type                   slot;
   meta_type                   pos;
   pix_type                    pixel;
   pix_type [STORE_ROWS-1:0]   lines;
   logic                       sum_valid;
   sum_type [NUM_CHAN-1:0]     sum;
   meta_type                   sum_meta;
   logic                       out_free;

   assign pixel        = {req_if.red_in, req_if.green_in, req_if.blue_in};
   assign req_if.ready = in_ready;
   assign accept       = req_if.valid && in_ready;

   bf7x7_csr #(.MAX_WIDTH(MAX_WIDTH)) u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (csr_psel),
      .penable   (csr_penable),
      .pwrite    (csr_pwrite),
      .paddr     (csr_paddr),
      .pwdata    (csr_pwdata),
      .prdata    (csr_prdata),
      .pready    (csr_pready),
      .width     (cfg_width),
      .height    (cfg_height),
      .cfg_write (cfg_write)
   );

   bf7x7_raster #(.MAX_WIDTH(MAX_WIDTH)) u_raster (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .cfg_write (cfg_write),
      .width     (cfg_width),
      .height    (cfg_height),
      .addr      (addr),
      .slot      (slot),
      .pos       (pos)
   );

   bf7x7_line_store #(.MAX_WIDTH(MAX_WIDTH)) u_line_store (
      .clock    (clock),
      .read_en  (in_ready),
      .write_en (accept),
      .slot     (slot),
      .addr     (addr),
      .wdata    (pixel),
      .rdata    (lines)
   );

   bf7x7_window u_window (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_if.valid),
      .pixel     (pixel),
      .pos       (pos),
      .lines     (lines),
      .out_free  (out_free),
      .in_ready  (in_ready),
      .sum_valid (sum_valid),
      .sum       (sum),
      .sum_meta  (sum_meta)
   );

   bf7x7_mean u_mean (
      .clock    (clock),
      .reset    (reset),
      .in_valid (sum_valid),
      .sum      (sum),
      .meta     (sum_meta),
      .free     (out_free),
      .rsp      (rsp_if)
   );

   // with the result register empty every stage can move, so the input is open
   `BF7X7_ASSERT_IMPLY(ready_when_out_empty_a, clock, reset, !rsp_if.valid, req_if.ready)

   // the last window of a frame sits at the bottom-right corner
   `BF7X7_ASSERT_IMPLY(last_window_corner_a, clock, reset,
      rsp_if.valid && rsp_if.frame_last,
      (rsp_if.anchor_x == ANCHOR_W'(cfg_width - DIM_W'(KERNEL_SIZE))) &&
      (rsp_if.anchor_y == ANCHOR_W'(cfg_height - DIM_W'(KERNEL_SIZE))))

   // the frame's last pixel sends the raster back to the top-left corner
   `BF7X7_ASSERT_NEXT(frame_wrap_a, clock, reset, accept && pos.last, !pos.emit)

endmodule

`default_nettype wire

/* bench/bf7x7_mean_checker.sv */
// watches the pixel, result and register ports of the box filter and checks every window mean
`default_nettype none

module bf7x7_mean_checker (
   input  wire logic                             clock,
   input  wire logic                             reset,
   bf7x7_req_if                                  req_mon,
   bf7x7_rsp_if                                  rsp_mon,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic                             csr_pready,
   input  wire logic [bf7x7_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [bf7x7_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output int                                    mismatch_count,
   output int                                    means_pending
);
   import bf7x7_pkg::*;

   localparam int LINE_LEN   = 2048;
   localparam int REPORT_CAP = 200;

   typedef struct packed {
      logic [ANCHOR_W-1:0] anchor_x;
      logic [ANCHOR_W-1:0] anchor_y;
      chan_type            blue_mean;
      chan_type            green_mean;
      chan_type            red_mean;
      logic                frame_last;
   } window_mean_type;

   window_mean_type  expected_means[$];
   pix_type          line_mem [STORE_ROWS][LINE_LEN];
   pix_type          window [KERNEL_SIZE][KERNEL_SIZE];
   dim_type          frame_width;
   dim_type          frame_height;
   logic [ROW_W-1:0] pos_col;
   logic [ROW_W-1:0] pos_row;
   int               reported;

   function automatic dim_type clamp_size(logic [CSR_DATA_W-1:0] word, int upper);
      dim_type v;
      v = word[DIM_W-1:0];
      if (int'(v) < KERNEL_SIZE) return dim_type'(KERNEL_SIZE);
      if (int'(v) > upper) return dim_type'(upper);
      return v;
   endfunction

   task automatic flag_field(string name, int want, int got);
      if (want != got) begin
         mismatch_count++;
         if (reported < REPORT_CAP) begin
            reported++;
            $error("%s: expected %0d, actual %0d", name, want, got);
         end
      end
   endtask

   // shift the window, pull the new right column from the line memories, compute the mean
   task automatic take_pixel(pix_type pix);
      int              sum_b;
      int              sum_g;
      int              sum_r;
      window_mean_type m;
      for (int t = 0; t < KERNEL_SIZE; t++) begin
         for (int f = 0; f < KERNEL_SIZE - 1; f++)
            window[t][f] = window[t][f+1];
         if (t < KERNEL_SIZE - 1)
            window[t][KERNEL_SIZE-1] = line_mem[(int'(pos_row) + t) % STORE_ROWS][pos_col];
         else
            window[t][KERNEL_SIZE-1] = pix;
      end
      line_mem[int'(pos_row) % STORE_ROWS][pos_col] = pix;

      if (int'(pos_col) >= KERNEL_SIZE - 1 && int'(pos_row) >= KERNEL_SIZE - 1) begin
         sum_b = 0;
         sum_g = 0;
         sum_r = 0;
         for (int t = 0; t < KERNEL_SIZE; t++) begin
            for (int f = 0; f < KERNEL_SIZE; f++) begin
               sum_b += window[t][f][CH_BLUE*CHAN_W +: CHAN_W];
               sum_g += window[t][f][CH_GREEN*CHAN_W +: CHAN_W];
               sum_r += window[t][f][CH_RED*CHAN_W +: CHAN_W];
            end
         end
         m.anchor_x   = ANCHOR_W'(int'(pos_col) - (KERNEL_SIZE - 1));
         m.anchor_y   = ANCHOR_W'(int'(pos_row) - (KERNEL_SIZE - 1));
         m.blue_mean  = chan_type'(sum_b / AREA);
         m.green_mean = chan_type'(sum_g / AREA);
         m.red_mean   = chan_type'(sum_r / AREA);
         m.frame_last = (int'(pos_col) == int'(frame_width) - 1) &&
                        (int'(pos_row) == int'(frame_height) - 1);
         expected_means.push_back(m);
      end

      if (int'(pos_col) + 1 >= int'(frame_width)) begin
         pos_col = '0;
         if (int'(pos_row) + 1 >= int'(frame_height))
            pos_row = '0;
         else
            pos_row = pos_row + 1'b1;
      end else begin
         pos_col = pos_col + 1'b1;
      end
   endtask

   always @(posedge clock) begin : watch
      window_mean_type got;
      window_mean_type want;
      if (reset) begin
         expected_means.delete();
         foreach (window[t, f])
            window[t][f] = '0;
         pos_col        = '0;
         pos_row        = '0;
         frame_width    = dim_type'(WIDTH_RESET);
         frame_height   = dim_type'(HEIGHT_RESET);
         mismatch_count = 0;
         reported       = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            // any register write restarts the frame
            case (reg_index_type'(csr_paddr[2]))
               REG_WIDTH: begin
                  frame_width = clamp_size(csr_pwdata, LINE_LEN);
               end
               REG_HEIGHT: begin
                  frame_height = clamp_size(csr_pwdata, MAX_HEIGHT);
               end
            endcase
            pos_col = '0;
            pos_row = '0;
         end

         if (req_mon.valid && req_mon.ready)
            take_pixel({req_mon.red_in, req_mon.green_in, req_mon.blue_in});

         if (rsp_mon.valid && rsp_mon.ready) begin
            got.anchor_x   = rsp_mon.anchor_x;
            got.anchor_y   = rsp_mon.anchor_y;
            got.blue_mean  = rsp_mon.blue_mean;
            got.green_mean = rsp_mon.green_mean;
            got.red_mean   = rsp_mon.red_mean;
            got.frame_last = rsp_mon.frame_last;
            if (expected_means.size() == 0) begin
               mismatch_count++;
               if (reported < REPORT_CAP) begin
                  reported++;
                  $error("result item with none expected: anchor %0d,%0d",
                         got.anchor_x, got.anchor_y);
               end
            end else begin
               want = expected_means.pop_front();
               flag_field("anchor_x", want.anchor_x, got.anchor_x);
               flag_field("anchor_y", want.anchor_y, got.anchor_y);
               flag_field("blue_mean", want.blue_mean, got.blue_mean);
               flag_field("green_mean", want.green_mean, got.green_mean);
               flag_field("red_mean", want.red_mean, got.red_mean);
               flag_field("frame_last", want.frame_last, got.frame_last);
            end
         end
      end
      means_pending = expected_means.size();
   end

endmodule

`default_nettype wire

/* bench/tb_box_filter_7x7_rgb_core.sv */
// stimulus, handshake timing and verdict for the 7x7 box filter core
`default_nettype none

module tb_box_filter_7x7_rgb_core;
   import bf7x7_pkg::*;

   localparam int STALL_LIMIT  = 3000;
   localparam int LONG_HOLD    = 400;
   localparam int SETTLE       = 12;
   localparam int RANDOM_ITEMS = 600;

   typedef enum int {
      PAT_RANDOM,
      PAT_BRIGHT,
      PAT_DARK,
      PAT_EXTREME,
      PAT_FLAT
   } pattern_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int mismatch_count;
   int means_pending;
   int idle_cycles;
   int long_hold_asked;
   int long_hold_served;
   bit steady;

   bf7x7_req_if req_bus ();
   bf7x7_rsp_if rsp_bus ();

   box_filter_7x7_rgb_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_bus),
      .rsp_if      (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   bf7x7_mean_checker mean_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_pready     (csr_pready),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .mismatch_count (mismatch_count),
      .means_pending  (means_pending)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   function automatic int draw_gap();
      if (steady) return 0;
      if ($urandom_range(0, 3) == 0) return 0;
      return $urandom_range(0, 17);
   endfunction

   function automatic chan_type pick_chan(pattern_type pat, chan_type level);
      case (pat)
         PAT_BRIGHT:  return chan_type'(CHAN_MAX);
         PAT_DARK:    return '0;
         PAT_FLAT:    return level;
         PAT_EXTREME: begin
            case ($urandom_range(0, 2))
               0:       return '0;
               1:       return chan_type'(CHAN_MAX);
               default: return chan_type'($urandom_range(0, CHAN_MAX));
            endcase
         end
         default:     return chan_type'($urandom_range(0, CHAN_MAX));
      endcase
   endfunction

   // register word for a wanted frame size, sometimes with junk above the 12 size bits
   function automatic logic [CSR_DATA_W-1:0] size_word(int size);
      logic [CSR_DATA_W-1:0] word;
      word = CSR_DATA_W'(size);
      if (size == KERNEL_SIZE && $urandom_range(0, 1) == 1)
         word = CSR_DATA_W'($urandom_range(0, KERNEL_SIZE));
      if ($urandom_range(0, 3) == 0)
         word[CSR_DATA_W-1:DIM_W] = (CSR_DATA_W - DIM_W)'($urandom);
      return word;
   endfunction

   task automatic write_reg(reg_index_type idx, logic [CSR_DATA_W-1:0] word);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata  <= word;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic send_pixel(chan_type b, chan_type g, chan_type r);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.blue_in  <= b;
      req_bus.green_in <= g;
      req_bus.red_in   <= r;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   task automatic send_run(int count, pattern_type pat);
      chan_type lvl_b;
      chan_type lvl_g;
      chan_type lvl_r;
      lvl_b = chan_type'($urandom_range(0, CHAN_MAX));
      lvl_g = chan_type'($urandom_range(0, CHAN_MAX));
      lvl_r = chan_type'($urandom_range(0, CHAN_MAX));
      for (int k = 0; k < count; k++)
         send_pixel(pick_chan(pat, lvl_b), pick_chan(pat, lvl_g), pick_chan(pat, lvl_r));
      req_bus.valid <= 1'b0;
   endtask

   // block idle: every mean back, then a SETTLE wait for anything still in flight
   task automatic drain();
      while (means_pending != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   // result side: random ready gaps per item, plus one long hold on request
   initial begin
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         int gap;
         if (long_hold_asked > long_hold_served) begin
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            long_hold_served++;
         end
         gap = draw_gap();
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready));
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
                   (csr_psel && csr_penable)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin
      int          cur_w;
      int          cur_h;
      int          new_w;
      int          new_h;
      int          count;
      int          phase;
      int          random_sent;
      int          sel;
      pattern_type pat;

      reset            = 1'b1;
      steady           = 1'b0;
      long_hold_asked  = 0;
      long_hold_served = 0;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;
      req_bus.valid    = 1'b0;
      req_bus.blue_in  = '0;
      req_bus.green_in = '0;
      req_bus.red_in   = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // default 640x480 frame: a few extreme pixels, no window completes
      send_pixel(8'h00, 8'h00, 8'h00);
      send_pixel(8'hFF, 8'hFF, 8'hFF);
      send_pixel(8'hAA, 8'h55, 8'hAA);
      send_pixel(8'h55, 8'hAA, 8'h55);
      send_pixel(8'hFF, 8'h00, 8'h80);
      send_pixel(8'h01, 8'hFE, 8'h7F);
      req_bus.valid <= 1'b0;
      drain();

      // sizes below range clamp to the smallest frame: one window per frame
      write_reg(REG_WIDTH, 32'd3);
      write_reg(REG_HEIGHT, 32'd0);
      send_run(KERNEL_SIZE * KERNEL_SIZE, PAT_BRIGHT);
      drain();
      send_run(KERNEL_SIZE * KERNEL_SIZE, PAT_DARK);
      drain();

      // widest line and tallest frame, each only partly filled
      steady = 1'b1;
      write_reg(REG_WIDTH, 32'd2048);
      write_reg(REG_HEIGHT, 32'd7);
      send_run(300, PAT_RANDOM);
      drain();
      write_reg(REG_WIDTH, 32'hDEAD_0006);
      write_reg(REG_HEIGHT, 32'h0000_0FFF);
      send_run(KERNEL_SIZE * 16, PAT_RANDOM);
      drain();
      cur_w = KERNEL_SIZE;
      cur_h = MAX_HEIGHT;

      phase       = 0;
      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         drain();
         steady = ($urandom_range(0, 4) == 0);
         if (phase > 2 && $urandom_range(0, 14) == 0) begin
            // width above range clamps to the widest line; only a partial frame fits here
            write_reg(REG_WIDTH, size_word($urandom_range(2049, 4095)));
            cur_w = 2048;
            count = $urandom_range(20, 300);
         end else begin
            case ($urandom_range(0, 19))
               0, 1, 2, 3, 4: new_w = $urandom_range(17, 40);
               5:             new_w = $urandom_range(41, 100);
               default:       new_w = $urandom_range(KERNEL_SIZE, 16);
            endcase
            new_h = ($urandom_range(0, 4) == 0) ? $urandom_range(12, 16)
                                                 : $urandom_range(KERNEL_SIZE, 11);
            sel = $urandom_range(0, 5);
            if (cur_w > 100 || cur_h > 100)
               sel = 2;
            if (sel != 1) begin
               write_reg(REG_WIDTH, size_word(new_w));
               cur_w = new_w;
            end
            if (sel != 0) begin
               write_reg(REG_HEIGHT, size_word(new_h));
               cur_h = new_h;
            end
            count = $urandom_range(1, 2) * cur_w * cur_h;
            if ($urandom_range(0, 3) == 0)
               count = count - $urandom_range(1, cur_w * cur_h - 1);
         end
         pat = pattern_type'($urandom_range(0, 4));

         if (phase == 1) begin
            // results back up while pixels keep coming
            steady = 1'b1;
            count  = 3 * cur_w * cur_h;
            long_hold_asked++;
            send_run(count, pat);
         end else if (phase == 2) begin
            // sender waits halfway through the run until every mean is out
            send_run(count / 2, pat);
            do @(negedge clock); while (means_pending != 0);
            send_run(count - count / 2, pat);
         end else begin
            send_run(count, pat);
         end
         random_sent += count;
         phase++;
      end

      while (means_pending != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
      if (mismatch_count == 0 && means_pending == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

`default_nettype wire
